// ===== src/sse_pkg.sv =====
// ----------------------------------------------------------------------------
// sse_pkg: shared types, constants and arithmetic helpers
// Fixed-point helpers, register indexes and lane control types for the
// stereo enhancer.
// ----------------------------------------------------------------------------
package sse_pkg;

	localparam int DEF_SAMPLE_RATE  = 48000;
	localparam int DEF_SAMPLE_WIDTH = 24;

	localparam int DATA_W   = 32;
	localparam int FOL_W    = 40;
	localparam int WIDE_W   = 72;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int NOISE_SHIFT = 16;

	localparam longint TWO_PI_Q30 = 64'sd6746518852;
	localparam longint CENTER_HZ  = 64'sd700;
	localparam logic signed [21:0] FOLLOW_K0 = 22'sd1288490;
	localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
	localparam logic [31:0] LFSR_SEED = 32'h0000_ACE1;

	localparam logic [1:0] LAST_FILT = 2'd2;
	localparam logic [2:0] LAST_TAP  = 3'd4;
	localparam logic [2:0] FIRST_FEEDBACK_TAP = 3'd3;

	localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_CONTOUR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CV_DEPTH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_EN    = 3'd5;

	typedef logic signed [WIDE_W-1:0] wide_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GAIN,
		ST_BIQUAD,
		ST_DEPTH,
		ST_ENV,
		ST_HPGATE,
		ST_PROC,
		ST_LOW,
		ST_DC,
		ST_OUT,
		ST_DONE
	} lane_state_t;

	typedef struct packed {
		logic [14:0] input_gain;
		logic [14:0] low_contour_gain;
		logic [14:0] process_gain;
		logic [15:0] cv_depth;
		logic [14:0] output_gain;
	} gains_t;

	typedef struct packed {
		logic start;
		logic take;
	} lane_ctrl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} lane_stat_t;

	// elaboration-time rounding helpers, round half up
	function automatic longint c_rshr(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint c_mq30(longint a, longint b);
		return c_rshr(a * b, 30);
	endfunction

	function automatic wide_t rnd_shr(wide_t v, int unsigned s);
		return (v + (wide_t'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic wide_t clamp(wide_t v, int unsigned bits);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< (bits - 1)) - wide_t'(1);
		lo = -hi - wide_t'(1);
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(wide_t v);
		wide_t c;
		c = clamp(v, DATA_W);
		return c[DATA_W-1:0];
	endfunction

	function automatic logic signed [FOL_W-1:0] sat40(wide_t v);
		wide_t c;
		c = clamp(v, FOL_W);
		return c[FOL_W-1:0];
	endfunction

	function automatic logic [31:0] lfsr_step(logic [31:0] s);
		if (s[0])
			return (s >> 1) ^ LFSR_MASK;
		return s >> 1;
	endfunction

endpackage

// ===== src/sse_in_if.sv =====
// ----------------------------------------------------------------------------
// sse_in_if: input sample pair channel
// valid/ready stream carrying one stereo input pair per beat.
// ----------------------------------------------------------------------------
interface sse_in_if #(parameter int SAMPLE_WIDTH = 24);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] left_in;
	logic signed [SAMPLE_WIDTH-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink (input valid, input left_in, input right_in, output ready);
endinterface

// ===== src/sse_out_if.sv =====
// ----------------------------------------------------------------------------
// sse_out_if: output sample pair channel
// valid/ready stream carrying one processed stereo pair per beat.
// ----------------------------------------------------------------------------
interface sse_out_if #(parameter int SAMPLE_WIDTH = 24);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] left_out;
	logic signed [SAMPLE_WIDTH-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ===== src/sse_noise.sv =====
// ----------------------------------------------------------------------------
// sse_noise: dither generator
// Galois LFSR, two steps per accepted beat when enabled (left, then right).
// ----------------------------------------------------------------------------
module sse_noise import sse_pkg::*; #(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic noise_enable,
	output logic signed [SAMPLE_WIDTH-1:0] noise_l,
	output logic signed [SAMPLE_WIDTH-1:0] noise_r
);

	logic [31:0] lfsr_q;
	logic [31:0] step1;
	logic [31:0] step2;

	function automatic logic signed [SAMPLE_WIDTH-1:0] low_bits(logic [31:0] v);
		logic signed [SAMPLE_WIDTH-1:0] t;
		t = SAMPLE_WIDTH'(v) << NOISE_SHIFT;
		return t >>> NOISE_SHIFT;
	endfunction

	assign step1 = lfsr_step(lfsr_q);
	assign step2 = lfsr_step(step1);

	always_comb begin
		noise_l = '0;
		noise_r = '0;
		if (noise_enable) begin
			noise_l = low_bits(step1);
			noise_r = low_bits(step2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= LFSR_SEED;
		end else if (advance && noise_enable) begin
			lfsr_q <= step2;
		end
	end

	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("noise LFSR reached the all-zero lockup state");

	a_lfsr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && noise_enable) |=> lfsr_q == $past(lfsr_q))
		else $error("noise LFSR moved without an enabled beat");

endmodule

// ===== src/sse_lane.sv =====
// ----------------------------------------------------------------------------
// sse_lane: one channel of the enhancer
// Sequencer around one 33x33 multiplier and one follower multiplier;
// each operation has an issue phase and a write-back phase.
// ----------------------------------------------------------------------------
module sse_lane import sse_pkg::*; #(
	parameter int SAMPLE_RATE  = DEF_SAMPLE_RATE,
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  lane_ctrl_t ctrl,
	input  gains_t gains,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic signed [SAMPLE_WIDTH-1:0] noise,
	output lane_stat_t stat,
	output logic signed [SAMPLE_WIDTH-1:0] result
);

	// coefficient build, Q30 then Q4.28
	localparam longint ONE_Q30 = 64'sd1 <<< 30;
	localparam longint OMEGA  = (TWO_PI_Q30 * CENTER_HZ + SAMPLE_RATE / 2) / SAMPLE_RATE;
	localparam longint OMEGA2 = c_mq30(OMEGA, OMEGA);
	localparam longint TS1 = (c_mq30(OMEGA, OMEGA2) + 3) / 6;
	localparam longint TC1 = (c_mq30(ONE_Q30, OMEGA2) + 1) / 2;
	localparam longint TS2 = (c_mq30(TS1, OMEGA2) + 10) / 20;
	localparam longint TC2 = (c_mq30(TC1, OMEGA2) + 6) / 12;
	localparam longint TS3 = (c_mq30(TS2, OMEGA2) + 21) / 42;
	localparam longint TC3 = (c_mq30(TC2, OMEGA2) + 15) / 30;
	localparam longint TS4 = (c_mq30(TS3, OMEGA2) + 36) / 72;
	localparam longint TC4 = (c_mq30(TC3, OMEGA2) + 28) / 56;
	localparam longint TS5 = (c_mq30(TS4, OMEGA2) + 55) / 110;
	localparam longint TC5 = (c_mq30(TC4, OMEGA2) + 45) / 90;
	localparam longint TS6 = (c_mq30(TS5, OMEGA2) + 78) / 156;
	localparam longint TC6 = (c_mq30(TC5, OMEGA2) + 66) / 132;
	localparam longint SIN_Q30 = OMEGA - TS1 + TS2 - TS3 + TS4 - TS5 + TS6;
	localparam longint COS_Q30 = ONE_Q30 - TC1 + TC2 - TC3 + TC4 - TC5 + TC6;
	localparam longint ALPHA = (SIN_Q30 * 50 + 11) / 23;
	localparam longint DEN   = ONE_Q30 + ALPHA;
	localparam longint B0    = ((64'sd1 <<< 60) + DEN / 2) / DEN;
	localparam longint B1    = -c_mq30(2 * COS_Q30, B0);
	localparam longint B2    = c_mq30(ONE_Q30 - ALPHA, B0);
	localparam longint LPA1  = c_mq30(ONE_Q30 - COS_Q30, B0);
	localparam longint HPS   = c_mq30(ONE_Q30 + COS_Q30, B0);

	localparam logic signed [31:0] FB1 = 32'(c_rshr(B1, 2));
	localparam logic signed [31:0] FB2 = 32'(c_rshr(B2, 2));
	localparam logic signed [31:0] LP0 = 32'(c_rshr(c_rshr(LPA1, 1), 2));
	localparam logic signed [31:0] LP1 = 32'(c_rshr(LPA1, 2));
	localparam logic signed [31:0] HP0 = 32'(c_rshr(c_rshr(HPS, 1), 2));
	localparam logic signed [31:0] HP1 = 32'(c_rshr(-HPS, 2));
	localparam logic signed [31:0] UNITY_Q28 = 32'sd1 <<< 28;

	localparam logic signed [31:0] COEF [3][5] = '{
		'{FB2, FB1, UNITY_Q28, FB1, FB2},
		'{LP0, LP1, LP0, FB1, FB2},
		'{HP0, HP1, HP0, FB1, FB2}
	};

	localparam wide_t CV_BIAS = wide_t'(1) <<< (SAMPLE_WIDTH - 1);

	lane_state_t state_q, state_nxt;

	logic        phase_q;
	logic [2:0]  tap_q;
	logic [1:0]  filt_q;

	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [SAMPLE_WIDTH-1:0] noise_q;
	logic signed [SAMPLE_WIDTH-1:0] result_q;
	logic signed [DATA_W-1:0] xi_q, xh0_q, xh1_q;
	logic signed [DATA_W-1:0] yh0_q [3];
	logic signed [DATA_W-1:0] yh1_q [3];
	logic signed [FOL_W-1:0]  env_q, dc_q;
	logic signed [DATA_W-1:0] cv_q, hpm_q, sv_q;
	logic signed [35:0]       t1_q;
	wide_t                    acc_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_s1;
	logic signed [DATA_W-1:0] fol_tgt;
	logic signed [FOL_W-1:0]  fol_s;
	logic signed [FOL_W:0]    fol_diff;
	logic signed [62:0]       fprod_s1;

	wide_t p, acc_nxt, scaled12, t1_w;
	logic signed [DATA_W-1:0] tap_x, bq_y, env_e, od;
	logic signed [FOL_W-1:0]  fol_nxt;
	logic signed [32:0]       mag;

	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_smp(wide_t v);
		wide_t c;
		c = clamp(v, SAMPLE_WIDTH);
		return c[SAMPLE_WIDTH-1:0];
	endfunction

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   if (ctrl.start) state_nxt = ST_GAIN;
			ST_GAIN:   if (phase_q) state_nxt = ST_BIQUAD;
			ST_BIQUAD: if (phase_q && filt_q == LAST_FILT && tap_q == LAST_TAP)
					state_nxt = ST_DEPTH;
			ST_DEPTH:  if (phase_q) state_nxt = ST_ENV;
			ST_ENV:    if (phase_q) state_nxt = ST_HPGATE;
			ST_HPGATE: if (phase_q) state_nxt = ST_PROC;
			ST_PROC:   if (phase_q) state_nxt = ST_LOW;
			ST_LOW:    if (phase_q) state_nxt = ST_DC;
			ST_DC:     if (phase_q) state_nxt = ST_OUT;
			ST_OUT:    if (phase_q) state_nxt = ST_DONE;
			ST_DONE:   if (ctrl.take) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// operand select
	always_comb begin
		case (tap_q)
			3'd0:    tap_x = xi_q;
			3'd1:    tap_x = xh0_q;
			3'd2:    tap_x = xh1_q;
			3'd3:    tap_x = yh0_q[filt_q];
			default: tap_x = yh1_q[filt_q];
		endcase
		mag   = xi_q[DATA_W-1] ? -33'(xi_q) : 33'(xi_q);
		env_e = sat32(rnd_shr(wide_t'(env_q), 8));
		od    = sat32(wide_t'(sv_q) - rnd_shr(wide_t'(dc_q), 8));
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_GAIN: begin
				mul_a = 33'(x_q);
				mul_b = $signed({18'b0, gains.input_gain});
			end
			ST_BIQUAD: begin
				mul_a = 33'(COEF[filt_q][tap_q]);
				mul_b = 33'(tap_x);
			end
			ST_DEPTH: begin
				mul_a = mag;
				mul_b = $signed({17'b0, gains.cv_depth});
			end
			ST_HPGATE: begin
				mul_a = 33'(yh0_q[2]);
				mul_b = 33'(env_e);
			end
			ST_PROC: begin
				mul_a = 33'(hpm_q);
				mul_b = $signed({18'b0, gains.process_gain});
			end
			ST_LOW: begin
				mul_a = 33'(yh0_q[1]);
				mul_b = $signed({18'b0, gains.low_contour_gain});
			end
			ST_OUT: begin
				mul_a = 33'(od);
				mul_b = $signed({18'b0, gains.output_gain});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		fol_tgt  = (state_q == ST_DC) ? sv_q : cv_q;
		fol_s    = (state_q == ST_DC) ? dc_q : env_q;
		fol_diff = (41'(fol_tgt) <<< 8) - 41'(fol_s);
	end

	// write back
	always_comb begin
		p        = wide_t'(prod_s1);
		acc_nxt  = (tap_q < FIRST_FEEDBACK_TAP) ? acc_q + p : acc_q - p;
		bq_y     = sat32(rnd_shr(acc_nxt, 28));
		scaled12 = rnd_shr(p, 12);
		t1_w     = scaled12;
		fol_nxt  = sat40(wide_t'(fol_s) + rnd_shr(wide_t'(fprod_s1), 32));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			tap_q   <= '0;
			filt_q  <= '0;
			xh0_q   <= '0;
			xh1_q   <= '0;
			for (int i = 0; i < 3; i++) begin
				yh0_q[i] <= '0;
				yh1_q[i] <= '0;
			end
			env_q <= '0;
			dc_q  <= '0;
		end else begin
			if (state_q == ST_IDLE || state_q == ST_DONE)
				phase_q <= 1'b0;
			else
				phase_q <= ~phase_q;
			if (state_q == ST_BIQUAD && phase_q) begin
				if (tap_q == LAST_TAP) begin
					tap_q <= '0;
					yh1_q[filt_q] <= yh0_q[filt_q];
					yh0_q[filt_q] <= bq_y;
					if (filt_q == LAST_FILT) begin
						filt_q <= '0;
						xh1_q  <= xh0_q;
						xh0_q  <= xi_q;
					end else begin
						filt_q <= filt_q + 2'd1;
					end
				end else begin
					tap_q <= tap_q + 3'd1;
				end
			end
			if (state_q == ST_ENV && phase_q)
				env_q <= fol_nxt;
			if (state_q == ST_DC && phase_q)
				dc_q <= fol_nxt;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= mul_a * mul_b;
		fprod_s1 <= FOLLOW_K0 * fol_diff;
		if (state_q == ST_IDLE && ctrl.start) begin
			x_q     <= sample;
			noise_q <= noise;
		end
		if (state_q == ST_GAIN)
			acc_q <= '0;
		else if (state_q == ST_BIQUAD && phase_q)
			acc_q <= (tap_q == LAST_TAP) ? '0 : acc_nxt;
		if (phase_q) begin
			case (state_q)
				ST_GAIN:   xi_q   <= sat32(scaled12);
				ST_DEPTH:  cv_q   <= sat32(CV_BIAS - scaled12);
				ST_HPGATE: hpm_q  <= sat32(rnd_shr(p, SAMPLE_WIDTH - 1));
				ST_PROC:   t1_q   <= t1_w[35:0];
				ST_LOW:    sv_q   <= sat32(wide_t'(yh0_q[0]) + wide_t'(t1_q) + scaled12);
				ST_OUT:    result_q <= sat_smp(scaled12 + wide_t'(noise_q));
				default:   ;
			endcase
		end
	end

	assign stat.idle = (state_q == ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign result    = result_q;

endmodule

// ===== src/stereo_sonic_enhancer_core.sv =====
// ----------------------------------------------------------------------------
// stereo_sonic_enhancer_core: stereo 700 Hz sonic enhancer
// Two channel lanes in lockstep, a dither generator and an output register.
// ----------------------------------------------------------------------------
// Each input beat carries one stereo pair of signed Q1.23 samples and yields
// exactly one output beat. Every channel is scaled by input_gain, filtered by
// fixed 700 Hz allpass, lowpass and highpass biquads, the highpass band is
// gated by an envelope follower, the bands are mixed, DC is tracked out,
// output_gain is applied and optional dither is added before saturation.
// Each lane runs 23 operations, each an issue and a write-back phase: 21
// go through one shared 33x33 multiplier (15 of them are the biquad taps)
// and the two follower updates through a follower multiplier. The lanes
// then hand off into the output register, which presents the pair. A new
// pair is taken in the cycle after the lanes hand their result to the
// output register, not while one is in process; a finished pair waiting
// in the output register does not stop the next input.
// Configuration writes, which are registered, must be issued while no pair
// is in flight. Filter coefficients are fixed at elaboration from SAMPLE_RATE.
// ----------------------------------------------------------------------------
module stereo_sonic_enhancer_core import sse_pkg::*; #(
	parameter int SAMPLE_RATE  = DEF_SAMPLE_RATE,
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	sse_in_if.sink    din,
	sse_out_if.source dout
);

	// configuration registers
	gains_t gains_q;
	logic   noise_en_q;

	// lane handshake
	lane_ctrl_t ctrl;
	lane_stat_t stat_l, stat_r;
	logic signed [SAMPLE_WIDTH-1:0] noise_l, noise_r;
	logic signed [SAMPLE_WIDTH-1:0] res_l, res_r;

	// output register (merge stage)
	logic out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] left_q, right_q;

	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.input_gain       <= 15'd4096;
			gains_q.low_contour_gain <= 15'd0;
			gains_q.process_gain     <= 15'd0;
			gains_q.cv_depth         <= 16'd8192;
			gains_q.output_gain      <= 15'd4096;
			noise_en_q               <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INPUT_GAIN:  gains_q.input_gain       <= cfg_wdata[14:0];
				REG_LOW_CONTOUR: gains_q.low_contour_gain <= cfg_wdata[14:0];
				REG_PROCESS:     gains_q.process_gain     <= cfg_wdata[14:0];
				REG_CV_DEPTH:    gains_q.cv_depth         <= cfg_wdata;
				REG_OUTPUT_GAIN: gains_q.output_gain      <= cfg_wdata[14:0];
				REG_NOISE_EN:    noise_en_q               <= cfg_wdata[0];
				default:         ;  // unmapped index, write dropped
			endcase
		end
	end

	// Both lanes start on the same beat and run the same schedule, so the
	// left lane's status stands for the pair.
	assign din.ready  = stat_l.idle;
	assign accept     = din.valid && din.ready;
	assign ctrl.start = accept;
	// hand off when the output register is empty or being drained this cycle
	assign ctrl.take  = stat_l.done && (!out_valid_q || dout.ready);

	// dither steps left then right on each accepted beat while enabled
	sse_noise #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_noise (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (accept),
		.noise_enable (noise_en_q),
		.noise_l      (noise_l),
		.noise_r      (noise_r)
	);

	sse_lane #(.SAMPLE_RATE(SAMPLE_RATE), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_l (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.gains  (gains_q),
		.sample (din.left_in),
		.noise  (noise_l),
		.stat   (stat_l),
		.result (res_l)
	);

	sse_lane #(.SAMPLE_RATE(SAMPLE_RATE), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_r (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.gains  (gains_q),
		.sample (din.right_in),
		.noise  (noise_r),
		.stat   (stat_r),
		.result (res_r)
	);

	// merge: both lane results into one output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.take) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			left_q  <= res_l;
			right_q <= res_r;
		end
	end

	assign dout.valid     = out_valid_q;
	assign dout.left_out  = left_q;
	assign dout.right_out = right_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !din.ready)
		else $error("input taken again while lanes are busy");

	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		stat_l == stat_r)
		else $error("left and right lanes out of step");

	a_out_from_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(stat_l.done))
		else $error("output beat raised without finished lanes");

endmodule
